/* sv/round_robin_free_server_assigner_defines.svh */
// Assertion macros for the round-robin free-server assigner checker.
// No dependencies; included by the checker file.
`ifndef ROUND_ROBIN_FREE_SERVER_ASSIGNER_DEFINES_SVH
`define ROUND_ROBIN_FREE_SERVER_ASSIGNER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RRFSA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define RRFSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rrfsa_pkg.sv */
// Shared constants and controller/datapath interface types for the
// round-robin free-server assigner. No dependencies.
package rrfsa_pkg;

  // Default sizes
  localparam int NUM_SERVERS_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;

  // Fixed field widths on the ports
  localparam int CFG_W       = 5;
  localparam int FIELD_T_W   = 32;
  localparam int SERVER_W    = 4;
  localparam int COUNT_W     = 32;
  localparam int MASK_W      = 16;
  localparam int IN_DATA_W   = 2 * FIELD_T_W;
  localparam int OUT_FIELD_W = SERVER_W + 1 + COUNT_W + MASK_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  // Reset value of the servers-in-use register
  localparam logic [CFG_W-1:0] SERVERS_IN_USE_RST = 5'd16;

  // Controller state codes
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_HOLD   = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;     // latch request, set up scan
    logic issue;     // read the table entry at the scan pointer, advance
    logic take;      // record the free server just found
    logic commit;    // write server state, best count, next preferred
    logic load_out;  // load the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic hit;         // entry read last cycle is free
    logic issued_all;  // a read has been issued for every server in use
    logic rd_valid;    // a read result is present this cycle
  } status_t;

endpackage

/* sv/rrfsa_ctrl.sv */
// Sequencing controller for the round-robin free-server assigner.
// Depends on rrfsa_pkg for state codes and the command/status types.
module rrfsa_ctrl import rrfsa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  output logic    m_tvalid,
  input  logic    m_tready,
  input  status_t status,
  output cmd_t    cmd
);

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid;

  // Decode commands from the state and status
  always_comb begin
    s_tready     = (state == ST_IDLE);
    cmd.start    = s_tvalid && (state == ST_IDLE);
    cmd.issue    = (state == ST_SCAN) && !status.issued_all && !status.hit;
    cmd.take     = (state == ST_SCAN) && status.hit;
    cmd.commit   = (state == ST_UPDATE);
    cmd.load_out = (state == ST_HOLD) && (!out_valid || m_tready);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.hit || (status.issued_all && !status.rd_valid)) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_valid || m_tready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Advance state, track the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;

endmodule

/* sv/rrfsa_datapath.sv */
// Datapath of the round-robin free-server assigner: server table memories,
// scan pointer, best-count tracking and output register. Uses rrfsa_pkg.
module rrfsa_datapath import rrfsa_pkg::*; #(
  parameter int NUM_SERVERS = NUM_SERVERS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int IW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int NW = $clog2(NUM_SERVERS + 1);
  localparam int BW = TIME_BITS + 1;

  // Server table: busy-until time and served count, one valid bit per entry
  logic [BW-1:0]          busy_mem [NUM_SERVERS];
  logic [COUNT_W-1:0]     cnt_mem  [NUM_SERVERS];
  logic [NUM_SERVERS-1:0] vld;

  logic [CFG_W-1:0]       servers_in_use;
  logic [IW-1:0]          next_pref;
  logic [COUNT_W-1:0]     best_count;
  logic [NUM_SERVERS-1:0] best_mask;

  logic [TIME_BITS-1:0]   arrival;
  logic [TIME_BITS-1:0]   length;
  logic [NW-1:0]          n_act;
  logic [IW-1:0]          pref;
  logic [IW-1:0]          ptr;
  logic [NW-1:0]          issued;

  logic                   rd_valid;
  logic                   rd_entry_vld;
  logic [BW-1:0]          rd_busy;
  logic [COUNT_W-1:0]     rd_cnt;
  logic [IW-1:0]          rd_addr;

  logic                   found;
  logic [IW-1:0]          chosen;
  logic [COUNT_W-1:0]     new_count;

  logic [7:0]             cfg_wide;
  logic [7:0]             n_wide;
  logic [NW-1:0]          n_clamped;
  logic [IW-1:0]          pref_start;
  logic [IW-1:0]          ptr_inc;
  logic [NW-1:0]          pref_inc;
  logic [BW-1:0]          eff_busy;
  logic [COUNT_W-1:0]     eff_cnt;
  logic [NUM_SERVERS-1:0] chosen_bit;

  // Clamp servers in use to 1..NUM_SERVERS, pick the starting server
  always_comb begin
    cfg_wide = {3'b000, servers_in_use};
    if (cfg_wide == 8'd0) begin
      n_wide = 8'd1;
    end else if (cfg_wide > 8'(NUM_SERVERS)) begin
      n_wide = 8'(NUM_SERVERS);
    end else begin
      n_wide = cfg_wide;
    end
    n_clamped  = NW'(n_wide);
    pref_start = (NW'(next_pref) >= n_clamped) ? '0 : next_pref;
  end

  // Circular wrap for the scan pointer and the preferred server
  always_comb begin
    ptr_inc  = ((NW'(ptr) + NW'(1)) == n_act) ? '0 : IW'(NW'(ptr) + NW'(1));
    pref_inc = NW'(pref) + NW'(1);
  end

  // Entry read last cycle, with unwritten entries seen as zero
  always_comb begin
    eff_busy   = rd_entry_vld ? rd_busy : '0;
    eff_cnt    = rd_entry_vld ? rd_cnt : '0;
    chosen_bit = NUM_SERVERS'(1) << chosen;
  end

  assign status.hit        = rd_valid && (eff_busy <= {1'b0, arrival});
  assign status.issued_all = (issued == n_act);
  assign status.rd_valid   = rd_valid;

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      servers_in_use <= SERVERS_IN_USE_RST;
    end else if (cfg_valid) begin
      servers_in_use <= cfg_data;
    end
  end

  // Latch the request and set up the scan
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      arrival <= TIME_BITS'(s_tdata[FIELD_T_W-1:0]);
      length  <= TIME_BITS'(s_tdata[IN_DATA_W-1:FIELD_T_W]);
      n_act   <= n_clamped;
      pref    <= pref_start;
    end
  end

  // Scan pointer and issue count
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ptr    <= pref_start;
      issued <= '0;
    end else if (cmd.issue) begin
      ptr    <= ptr_inc;
      issued <= issued + NW'(1);
    end
  end

  // Registered table read
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_busy      <= busy_mem[ptr];
      rd_cnt       <= cnt_mem[ptr];
      rd_entry_vld <= vld[ptr];
      rd_addr      <= ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.issue;
    end
  end

  // Record the free server found, with saturating count
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.start) begin
      found <= 1'b0;
    end else if (cmd.take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      chosen    <= rd_addr;
      new_count <= (eff_cnt == '1) ? eff_cnt : eff_cnt + COUNT_W'(1);
    end
  end

  // Write the server table
  always_ff @(posedge clk) begin
    if (cmd.commit && found) begin
      busy_mem[chosen] <= {1'b0, arrival} + {1'b0, length};
      cnt_mem[chosen]  <= new_count;
    end
  end

  // Valid bits, best count and mask, preferred server
  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      best_count <= '0;
      best_mask  <= '1;
      next_pref  <= '0;
    end else if (cmd.commit) begin
      next_pref <= (pref_inc >= n_act) ? '0 : IW'(pref_inc);
      if (found) begin
        vld <= vld | chosen_bit;
        if (new_count > best_count) begin
          best_count <= new_count;
          best_mask  <= chosen_bit;
        end else if (new_count == best_count) begin
          best_mask <= best_mask | chosen_bit;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= OUT_DATA_W'({MASK_W'(best_mask), best_count, !found,
                              found ? SERVER_W'(chosen) : SERVER_W'(0)});
    end
  end

endmodule

/* sv/round_robin_free_server_assigner.sv */
// Round-robin free-server assigner. Request i prefers server i mod N and takes
// the first server, searching circularly from there, whose busy-until time is
// at or before the arrival time; with none free it is dropped. After the accept
// state, the search reads one server table entry per cycle through a single
// registered memory port, and the request then passes through the update and
// output-load states. On a drop the search ends only once the last entry read
// has come back. The next request is taken while a result waits in the output
// register; it then holds in its last cycle until that result is taken.
// Configuration writes are accepted in every cycle and must be made while the
// block is idle.
module round_robin_free_server_assigner import rrfsa_pkg::*; #(
  parameter int NUM_SERVERS = NUM_SERVERS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Servers-in-use register write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data,
  // Request stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // arrival_time[31:0], service_length[63:32]
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // assigned_server[3:0], dropped[4],
                                           // top_count[36:5], top_servers_mask[52:37],
                                           // zero[55:53]
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  rrfsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rrfsa_datapath #(
    .NUM_SERVERS (NUM_SERVERS),
    .TIME_BITS   (TIME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tdata   (m_tdata)
  );

endmodule

/* sv/rrfsa_checker.sv */
// Port-level checker for the round-robin free-server assigner, bound to the
// top level. Uses rrfsa_pkg and the assertion macros header.
`include "round_robin_free_server_assigner_defines.svh"

module rrfsa_checker import rrfsa_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // A dropped result reports server zero
  `RRFSA_ASSERT_NOW(a_drop_server_zero, clk, rst, m_tvalid && m_tdata[4], m_tdata[3:0] == 4'd0, "dropped result with nonzero server")

  // A served request leaves a nonzero top count
  `RRFSA_ASSERT_NOW(a_served_top_nonzero, clk, rst, m_tvalid && !m_tdata[4], m_tdata[36:5] != 32'd0, "served result with zero top count")

  // One request is in work at a time
  `RRFSA_ASSERT_NEXT(a_one_in_work, clk, rst, s_tvalid && s_tready, !s_tready, "request accepted while another in work")

  // Hold a stalled result
  `RRFSA_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind round_robin_free_server_assigner rrfsa_checker u_rrfsa_checker (.*);
